/* rtl/core/tsac_pkg.sv */
// Shared constants and codes for the touch sample averaging and calibration block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package tsac_pkg;

    localparam int COORD_BITS_DEF    = 10;
    localparam int COEF_W            = 32;
    localparam int DIVR_W            = 31;
    localparam int CFG_IDX_W         = 3;
    localparam int CNT_W             = 3;
    localparam int SAMPLES_PER_POINT = 4;
    localparam int SCREEN_W          = 320;
    localparam int SCREEN_H          = 240;
    localparam int COORD_SCALE       = 1024;
    localparam int SCALE_SHIFT       = 10;
    localparam int DIVIDER_RESET     = 65536;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_COEF_YX  = 3'd3,
        REG_COEF_YY  = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_DIVIDER  = 3'd6,
        REG_CAL_EN   = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACT_CONVERT  = 2'd0,
        ACT_CHECK    = 2'd1,
        ACT_WAIT_PEN = 2'd2
    } action_t;

endpackage

`default_nettype wire

/* rtl/core/tsac_mac.sv */
// Bit-serial multiply-accumulate: a*px + b*py + c, one bit of px/py per cycle, MSB first.
// Depends on tsac_pkg for the coefficient width.
`default_nettype none

module tsac_mac #(
    parameter int COORD_BITS = tsac_pkg::COORD_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [tsac_pkg::COEF_W-1:0]    coef_a,
    input  wire logic signed [tsac_pkg::COEF_W-1:0]    coef_b,
    input  wire logic signed [tsac_pkg::COEF_W-1:0]    offset,
    input  wire logic        [COORD_BITS-1:0]          px,
    input  wire logic        [COORD_BITS-1:0]          py,
    output logic                                       done,
    output logic signed      [tsac_pkg::COEF_W+COORD_BITS+1:0] acc
);

    localparam int AW = tsac_pkg::COEF_W + COORD_BITS + 2;
    localparam int CW = $clog2(COORD_BITS + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [COORD_BITS-1:0]  px_sh_reg, px_sh_next;
    logic [COORD_BITS-1:0]  py_sh_reg, py_sh_next;
    logic signed [AW-1:0]   acc_reg, acc_next;
    logic signed [AW-1:0]   term_a, term_b, offset_ext;

    assign term_a = px_sh_reg[COORD_BITS-1]
                  ? {{(AW-tsac_pkg::COEF_W){coef_a[tsac_pkg::COEF_W-1]}}, coef_a} : '0;
    assign term_b = py_sh_reg[COORD_BITS-1]
                  ? {{(AW-tsac_pkg::COEF_W){coef_b[tsac_pkg::COEF_W-1]}}, coef_b} : '0;
    assign offset_ext = {{(AW-tsac_pkg::COEF_W){offset[tsac_pkg::COEF_W-1]}}, offset};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        px_sh_next = px_sh_reg;
        py_sh_next = py_sh_reg;
        acc_next   = acc_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CW'(COORD_BITS);
            px_sh_next = px;
            py_sh_next = py;
            acc_next   = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                // Horner step: double, then add the selected coefficients
                acc_next   = (acc_reg <<< 1) + term_a + term_b;
                px_sh_next = px_sh_reg << 1;
                py_sh_next = py_sh_reg << 1;
                cnt_next   = cnt_reg - CW'(1);
            end
            else
            begin
                acc_next  = acc_reg + offset_ext;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            px_sh_reg <= '0;
            py_sh_reg <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            px_sh_reg <= px_sh_next;
            py_sh_reg <= py_sh_next;
            acc_reg   <= acc_next;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

/* rtl/core/tsac_div.sv */
// Restoring unsigned divider, one quotient bit per cycle, run for a chosen number of steps.
// Depends on tsac_pkg for the divisor width.
`default_nettype none

module tsac_div #(
    parameter int DW = 43,
    parameter int IW = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [DW-1:0]                 dividend,
    input  wire logic [tsac_pkg::DIVR_W-1:0]   divisor,
    input  wire logic [IW-1:0]                 iters,
    output logic                               done,
    output logic [DW-1:0]                      quotient
);

    localparam int RW = tsac_pkg::DIVR_W;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [IW-1:0]   cnt_reg, cnt_next;
    logic [DW-1:0]   dvd_reg, dvd_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [RW-1:0]   dvs_reg, dvs_next;
    logic [RW:0]     trial, diff;
    logic            fits;

    // remainder stays below the divisor, so the trial value fits RW+1 bits
    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = !diff[RW];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = iters;
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[RW-1:0] : trial[RW-1:0];
            dvd_next = {dvd_reg[DW-2:0], fits};
            cnt_next = cnt_reg - IW'(1);
            if (cnt_reg == IW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            dvd_reg  <= dvd_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

/* rtl/core/touch_sample_average_calibrate.sv */
// Touch sample averaging and calibration, top level: registers, sequencer, output stage.
// Depends on tsac_pkg, tsac_mac (serial multiply-accumulate) and tsac_div (serial divider).
// A sample, a pen-up check or an uncalibrated check is registered into the output register on its
// transfer in, or into the holding entry while the output stalls; one such item per cycle while the
// output drains. A calibrated check runs two passes (screen x, then screen y), each through the
// bit-serial MAC and the divider: a quotient of 33+COORD_BITS bits for the affine step, then one of
// COORD_BITS+9 bits for the screen scaling; a zero divider or an out-of-range quotient cuts it short.
// Reset clears all state; divider resets to 65536, other configuration to zero; no clearing pass.
`default_nettype none

module touch_sample_average_calibrate #(
    parameter int COORD_BITS = tsac_pkg::COORD_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata from bit 0: x_sample, y_sample, x_up_bit, y_up_bit, zero fill
    input  wire logic [((2*COORD_BITS+2+7)/8)*8-1:0] s_tdata,
    // s_tuser: operation
    input  wire logic                               s_tuser,
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata from bit 0: screen_x, screen_y, next_action, zero fill
    output logic [((2*COORD_BITS+2+7)/8)*8-1:0]     m_tdata,
    // m_tuser from bit 0: report_valid, touch
    output logic [1:0]                              m_tuser,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tsac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tsac_pkg::COEF_W-1:0]        cfg_data
);

    localparam int CB     = COORD_BITS;
    localparam int SUM_W  = CB + 2;
    localparam int PAY_W  = 2 * CB + 2;
    localparam int TD_W   = ((PAY_W + 7) / 8) * 8;
    localparam int AW     = tsac_pkg::COEF_W + CB + 2;  // signed affine sum
    localparam int MW     = AW - 1;                     // its magnitude
    localparam int IW     = $clog2(MW + 1);
    localparam int SN     = CB + tsac_pkg::SCALE_SHIFT - 1;  // bits of q*1024 below the clamp
    localparam int THR_XI = (tsac_pkg::SCREEN_W * (2 ** CB)) / tsac_pkg::COORD_SCALE;
    localparam int THR_YI = (tsac_pkg::SCREEN_H * (2 ** CB)) / tsac_pkg::COORD_SCALE;
    localparam logic [MW-1:0] THR_X = MW'(THR_XI);
    localparam logic [MW-1:0] THR_Y = MW'(THR_YI);
    localparam logic [tsac_pkg::CNT_W-1:0] SPP = tsac_pkg::CNT_W'(tsac_pkg::SAMPLES_PER_POINT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_MAC,
        ST_DIV
    } state_t;

    // ST_DIV covers both the affine division and the screen scaling; scale_reg tells which

    // ---------------- configuration registers ----------------
    logic signed [tsac_pkg::COEF_W-1:0] coef_xx_reg, coef_xy_reg, offset_x_reg;
    logic signed [tsac_pkg::COEF_W-1:0] coef_yx_reg, coef_yy_reg, offset_y_reg;
    logic [tsac_pkg::DIVR_W-1:0]        divider_reg;
    logic                               cal_en_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg  <= '0;
            coef_xy_reg  <= '0;
            offset_x_reg <= '0;
            coef_yx_reg  <= '0;
            coef_yy_reg  <= '0;
            offset_y_reg <= '0;
            divider_reg  <= tsac_pkg::DIVR_W'(tsac_pkg::DIVIDER_RESET);
            cal_en_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (tsac_pkg::cfg_reg_t'(cfg_index))
                tsac_pkg::REG_COEF_XX:  coef_xx_reg  <= cfg_data;
                tsac_pkg::REG_COEF_XY:  coef_xy_reg  <= cfg_data;
                tsac_pkg::REG_OFFSET_X: offset_x_reg <= cfg_data;
                tsac_pkg::REG_COEF_YX:  coef_yx_reg  <= cfg_data;
                tsac_pkg::REG_COEF_YY:  coef_yy_reg  <= cfg_data;
                tsac_pkg::REG_OFFSET_Y: offset_y_reg <= cfg_data;
                tsac_pkg::REG_DIVIDER:  divider_reg  <= cfg_data[tsac_pkg::DIVR_W-1:0];
                tsac_pkg::REG_CAL_EN:   cal_en_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- input fields ----------------
    logic [CB-1:0] in_x, in_y;
    logic          in_x_up, in_y_up, in_op;

    assign in_x    = s_tdata[CB-1:0];
    assign in_y    = s_tdata[2*CB-1:CB];
    assign in_x_up = s_tdata[2*CB];
    assign in_y_up = s_tdata[2*CB+1];
    assign in_op   = s_tuser;

    // ---------------- sequencer state ----------------
    state_t                      state_reg, state_next;
    logic                        sel_reg, sel_next;      // 0 screen x pass, 1 screen y pass
    logic                        scale_reg, scale_next;  // divider busy with the 1024/W step
    logic                        neg_reg, neg_next;
    logic [SUM_W-1:0]            x_sum_reg, x_sum_next;
    logic [SUM_W-1:0]            y_sum_reg, y_sum_next;
    logic [tsac_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CB-1:0]               px_reg, px_next;
    logic [CB-1:0]               py_reg, py_next;
    logic [CB-1:0]               sx_reg, sx_next;

    // output stage: one register plus one holding entry
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [TD_W-1:0]             m_tdata_reg, m_tdata_next;
    logic [1:0]                  m_tuser_reg, m_tuser_next;
    logic                        pend_reg, pend_next;
    logic [TD_W-1:0]             hold_tdata_reg, hold_tdata_next;
    logic [1:0]                  hold_tuser_reg, hold_tuser_next;

    // ---------------- arithmetic units ----------------
    logic                               mac_start, mac_done;
    logic signed [AW-1:0]               mac_acc;
    logic signed [tsac_pkg::COEF_W-1:0] sel_a, sel_b, sel_c;
    logic                               div_start, div_done;
    logic [MW-1:0]                      div_dvd, div_quo;
    logic [tsac_pkg::DIVR_W-1:0]        div_dvs;
    logic [IW-1:0]                      div_iters;
    logic [MW-1:0]                      acc_mag;
    logic [SN-1:0]                      scaled;

    assign sel_a = sel_reg ? coef_yx_reg  : coef_xx_reg;
    assign sel_b = sel_reg ? coef_yy_reg  : coef_xy_reg;
    assign sel_c = sel_reg ? offset_y_reg : offset_x_reg;

    tsac_mac #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .coef_a (sel_a),
        .coef_b (sel_b),
        .offset (sel_c),
        .px     (px_reg),
        .py     (py_reg),
        .done   (mac_done),
        .acc    (mac_acc)
    );

    tsac_div #(
        .DW (MW),
        .IW (IW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .iters    (div_iters),
        .done     (div_done),
        .quotient (div_quo)
    );

    // |sum| is below 2**MW, so the magnitude never overflows
    assign acc_mag = mac_acc[AW-1] ? MW'(~mac_acc + AW'(1)) : mac_acc[MW-1:0];
    // quotient below the clamp threshold fits SN-SCALE_SHIFT bits; q*1024 placed at the top
    assign scaled  = {div_quo[SN-tsac_pkg::SCALE_SHIFT-1:0], {tsac_pkg::SCALE_SHIFT{1'b0}}};

    // ---------------- next-state logic ----------------
    logic              accept;
    logic              res_v;
    logic              res_rv, res_touch;
    logic [CB-1:0]     res_sx, res_sy;
    tsac_pkg::action_t res_act;
    logic [TD_W-1:0]   res_tdata;
    logic [1:0]        res_tuser;
    logic              coord_done;
    logic [CB-1:0]     coord_val;
    logic [CB-1:0]     px_now, py_now;

    assign s_tready = (state_reg == ST_IDLE) && !pend_reg;
    assign accept   = s_tvalid && s_tready;
    // swap axes and invert the new y: average = sum / 4
    assign px_now   = y_sum_reg[SUM_W-1:2];
    assign py_now   = ~x_sum_reg[SUM_W-1:2];

    assign res_tdata = TD_W'({res_act, res_sy, res_sx});
    assign res_tuser = {res_touch, res_rv};

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        scale_next = scale_reg;
        neg_next   = neg_reg;
        x_sum_next = x_sum_reg;
        y_sum_next = y_sum_reg;
        cnt_next   = cnt_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        sx_next    = sx_reg;
        mac_start  = 1'b0;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dvs    = '0;
        div_iters  = '0;
        res_v      = 1'b0;
        res_rv     = 1'b0;
        res_touch  = 1'b0;
        res_sx     = '0;
        res_sy     = '0;
        res_act    = tsac_pkg::ACT_CONVERT;
        coord_done = 1'b0;
        coord_val  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_v = 1'b1;
                    if (in_op == tsac_pkg::OP_SAMPLE)
                    begin
                        if (cnt_reg < SPP)
                        begin
                            x_sum_next = x_sum_reg + SUM_W'(in_x);
                            y_sum_next = y_sum_reg + SUM_W'(in_y);
                            cnt_next   = cnt_reg + tsac_pkg::CNT_W'(1);
                            res_act    = ((cnt_reg + tsac_pkg::CNT_W'(1)) < SPP)
                                       ? tsac_pkg::ACT_CONVERT : tsac_pkg::ACT_CHECK;
                        end
                        else
                        begin
                            // point already full: sample dropped
                            res_act = tsac_pkg::ACT_CHECK;
                        end
                    end
                    else
                    begin
                        x_sum_next = '0;
                        y_sum_next = '0;
                        cnt_next   = '0;
                        if (in_x_up || in_y_up)
                        begin
                            res_rv  = 1'b1;
                            res_act = tsac_pkg::ACT_WAIT_PEN;
                        end
                        else if (cnt_reg == '0)
                        begin
                            // pen down but nothing averaged: empty result
                        end
                        else if (!cal_en_reg)
                        begin
                            res_rv    = 1'b1;
                            res_touch = 1'b1;
                            res_sx    = px_now;
                            res_sy    = py_now;
                        end
                        else
                        begin
                            res_v      = 1'b0;
                            px_next    = px_now;
                            py_next    = py_now;
                            sel_next   = 1'b0;
                            state_next = ST_START;
                        end
                    end
                end
            end

            ST_START:
            begin
                mac_start  = 1'b1;
                state_next = ST_MAC;
            end

            ST_MAC:
            begin
                if (mac_done)
                begin
                    if (divider_reg == '0)
                    begin
                        // zero divider: quotient taken as zero
                        coord_done = 1'b1;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_dvd    = acc_mag;
                        div_dvs    = divider_reg;
                        div_iters  = IW'(MW);
                        neg_next   = mac_acc[AW-1];
                        scale_next = 1'b0;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    if (scale_reg)
                    begin
                        coord_done = 1'b1;
                        coord_val  = div_quo[CB-1:0];
                    end
                    else if (neg_reg || (div_quo == '0))
                    begin
                        // truncation toward zero keeps the result at or below zero
                        coord_done = 1'b1;
                    end
                    else if (div_quo >= (sel_reg ? THR_Y : THR_X))
                    begin
                        coord_done = 1'b1;
                        coord_val  = '1;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_dvd    = {scaled, {(MW-SN){1'b0}}};
                        div_dvs    = sel_reg ? tsac_pkg::DIVR_W'(tsac_pkg::SCREEN_H)
                                             : tsac_pkg::DIVR_W'(tsac_pkg::SCREEN_W);
                        div_iters  = IW'(SN);
                        scale_next = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (coord_done)
        begin
            if (!sel_reg)
            begin
                sx_next    = coord_val;
                sel_next   = 1'b1;
                state_next = ST_START;
            end
            else
            begin
                res_v      = 1'b1;
                res_rv     = 1'b1;
                res_touch  = 1'b1;
                res_sx     = sx_reg;
                res_sy     = coord_val;
                sel_next   = 1'b0;
                state_next = ST_IDLE;
            end
        end

        // output register and holding entry
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        pend_next       = pend_reg;
        hold_tdata_next = hold_tdata_reg;
        hold_tuser_next = hold_tuser_reg;
        if (!m_tvalid_reg || m_tready)
        begin
            if (pend_reg)
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = hold_tdata_reg;
                m_tuser_next  = hold_tuser_reg;
                pend_next     = 1'b0;
            end
            else if (res_v)
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = res_tdata;
                m_tuser_next  = res_tuser;
            end
            else
            begin
                m_tvalid_next = 1'b0;
            end
        end
        else if (res_v)
        begin
            pend_next       = 1'b1;
            hold_tdata_next = res_tdata;
            hold_tuser_next = res_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sel_reg        <= 1'b0;
            scale_reg      <= 1'b0;
            neg_reg        <= 1'b0;
            x_sum_reg      <= '0;
            y_sum_reg      <= '0;
            cnt_reg        <= '0;
            px_reg         <= '0;
            py_reg         <= '0;
            sx_reg         <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
            pend_reg       <= 1'b0;
            hold_tdata_reg <= '0;
            hold_tuser_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sel_reg        <= sel_next;
            scale_reg      <= scale_next;
            neg_reg        <= neg_next;
            x_sum_reg      <= x_sum_next;
            y_sum_reg      <= y_sum_next;
            cnt_reg        <= cnt_next;
            px_reg         <= px_next;
            py_reg         <= py_next;
            sx_reg         <= sx_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
            m_tuser_reg    <= m_tuser_next;
            pend_reg       <= pend_next;
            hold_tdata_reg <= hold_tdata_next;
            hold_tuser_reg <= hold_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- checks ----------------
    // a held result only exists behind a full output register
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> m_tvalid_reg)
        else $error("holding entry used while output register empty");

    // no new result may arrive while one is already held
    a_no_result_on_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !res_v)
        else $error("result produced while holding entry full");

    // the point never holds more than four samples
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SPP)
        else $error("sample count beyond one point");

    // no transfer in while a calibration pass is running
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken during calibration");

endmodule

`default_nettype wire
